// ===== rtl/irsd_pkg.sv =====
// Package for the image row subsample downscaler.
// Holds the transaction payload types, step state, register codes and reset values.
// No dependencies.
package irsd_pkg;

    // Field widths
    localparam int CHAN_W   = 8;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 2;
    localparam int IDX_W    = 12;
    localparam int SUM_W    = 10;
    localparam int HREM_W   = 16;
    localparam int CNT_W    = 13;
    localparam int SPL_W    = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOURCE_WIDTH  = 2'd0,
        REG_SOURCE_HEIGHT = 2'd1,
        REG_TARGET_WIDTH  = 2'd2,
        REG_TARGET_HEIGHT = 2'd3
    } t_cfg_reg;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_SOURCE_WIDTH  = 13'd640;
    localparam logic [CFG_W-1:0] RST_SOURCE_HEIGHT = 13'd480;
    localparam logic [CFG_W-1:0] RST_TARGET_WIDTH  = 13'd64;
    localparam logic [CFG_W-1:0] RST_TARGET_HEIGHT = 13'd64;

    // Reciprocal of three for sums up to 765: floor(x*683 / 2048) == floor(x/3)
    localparam logic [SUM_W-1:0] RECIP3     = 10'd683;
    localparam int               RECIP3_SH  = 11;
    localparam logic [SPL_W-1:0] SAMPLES_PER_PIXEL = 2'd3;

    typedef struct packed {
        logic [CHAN_W-1:0] chan_first;
        logic [CHAN_W-1:0] chan_second;
        logic [CHAN_W-1:0] chan_third;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_W-1:0] avg_of_third;
        logic [CHAN_W-1:0] avg_of_second;
        logic [CHAN_W-1:0] avg_of_first;
        logic [IDX_W-1:0]  out_column;
        logic [IDX_W-1:0]  out_row;
        logic              frame_done;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0] source_width;
        logic [CFG_W-1:0] source_height;
        logic [CFG_W-1:0] target_width;
        logic [CFG_W-1:0] target_height;
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0]  src_column;
        logic [CNT_W-1:0]  src_row;
        logic [CNT_W-1:0]  dst_column;
        logic [CNT_W-1:0]  dst_row;
        logic [SPL_W-1:0]  sample_in_pixel;
        logic [HREM_W-1:0] horiz_remainder;
        logic [CFG_W-1:0]  vert_remainder;
        logic [SUM_W-1:0]  sum_first;
        logic [SUM_W-1:0]  sum_second;
        logic [SUM_W-1:0]  sum_third;
    } t_state;

endpackage

// ===== rtl/irsd_step.sv =====
// Per-pixel step logic of the downscaler: size clamping, three-sample box
// accumulation, remainder stepping and row/frame wrap. Depends on irsd_pkg.
module irsd_step #(
    parameter int MAX_DIM = 4096
) (
    input  irsd_pkg::t_cfg      i_cfg,
    input  irsd_pkg::t_state    i_state,
    input  irsd_pkg::t_in_item  i_pixel,
    output irsd_pkg::t_state    o_state,
    output logic                o_emit,
    output irsd_pkg::t_out_item o_result
);
    import irsd_pkg::*;

    // Largest size a 13-bit register can express after clamping
    localparam int CFG_MAX  = (1 << CFG_W) - 1;
    localparam int DIM_CLIP = (MAX_DIM > CFG_MAX) ? CFG_MAX : MAX_DIM;

    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0) r = CFG_W'(1);
        else if (v > CFG_W'(DIM_CLIP)) r = CFG_W'(DIM_CLIP);
        return r;
    endfunction

    logic [CFG_W-1:0]    sw, sh, tw, th, tw_c, th_c;
    logic [CFG_W+1:0]    span;
    logic                row_active;
    logic                go;
    logic [HREM_W:0]     hr;
    logic [SPL_W-1:0]    spl;
    logic [SUM_W-1:0]    s1, s2, s3;
    logic [SUM_W-1:0]    e1, e2, e3;
    logic [CNT_W-1:0]    dcol, ecol;
    logic [2*SUM_W-1:0]  q1, q2, q3;
    logic [CFG_W:0]      vr_sum;

    always_comb begin
        sw   = clamp_dim(i_cfg.source_width);
        sh   = clamp_dim(i_cfg.source_height);
        tw_c = clamp_dim(i_cfg.target_width);
        th_c = clamp_dim(i_cfg.target_height);
        tw   = (tw_c > sw) ? sw : tw_c;
        th   = (th_c > sh) ? sh : th_c;
        span = (CFG_W+2)'({tw, 1'b0}) + (CFG_W+2)'(tw);
        row_active = (i_state.dst_row < th) && (i_state.vert_remainder < th);

        o_state = i_state;
        o_emit  = 1'b0;
        go   = row_active;
        hr   = (HREM_W+1)'(i_state.horiz_remainder);
        spl  = i_state.sample_in_pixel;
        s1   = i_state.sum_first;
        s2   = i_state.sum_second;
        s3   = i_state.sum_third;
        dcol = i_state.dst_column;
        e1   = '0;
        e2   = '0;
        e3   = '0;
        ecol = '0;

        // Up to three samples of the box filter land on one source pixel
        for (int k = 0; k < 3; k++) begin
            if (go && (dcol < tw) && (hr < (HREM_W+1)'(span))) begin
                s1  = s1 + SUM_W'(i_pixel.chan_first);
                s2  = s2 + SUM_W'(i_pixel.chan_second);
                s3  = s3 + SUM_W'(i_pixel.chan_third);
                spl = spl + SPL_W'(1);
                hr  = hr + (HREM_W+1)'(sw);
                if (spl == SAMPLES_PER_PIXEL) begin
                    o_emit = 1'b1;
                    e1   = s1;
                    e2   = s2;
                    e3   = s3;
                    ecol = dcol;
                    dcol = dcol + CNT_W'(1);
                    spl  = '0;
                    s1   = '0;
                    s2   = '0;
                    s3   = '0;
                end
            end else begin
                go = 1'b0;
            end
        end

        // Divide the box sums by three
        q1 = e1 * RECIP3;
        q2 = e2 * RECIP3;
        q3 = e3 * RECIP3;
        o_result.avg_of_first  = CHAN_W'(q1 >> RECIP3_SH);
        o_result.avg_of_second = CHAN_W'(q2 >> RECIP3_SH);
        o_result.avg_of_third  = CHAN_W'(q3 >> RECIP3_SH);
        o_result.out_column    = ecol[IDX_W-1:0];
        o_result.out_row       = i_state.dst_row[IDX_W-1:0];
        o_result.frame_done    = ((CNT_W+1)'(ecol) + (CNT_W+1)'(1) == (CNT_W+1)'(tw)) &&
                                 ((CNT_W+1)'(i_state.dst_row) + (CNT_W+1)'(1)
                                  == (CNT_W+1)'(th));

        // Advance horizontal state only on a row that feeds output
        if (row_active) begin
            o_state.sample_in_pixel = spl;
            o_state.sum_first       = s1;
            o_state.sum_second      = s2;
            o_state.sum_third       = s3;
            o_state.dst_column      = dcol;
            if (hr >= (HREM_W+1)'(span))
                o_state.horiz_remainder = HREM_W'(hr - (HREM_W+1)'(span));
            else
                o_state.horiz_remainder = '0;
        end

        // Row and frame wrap
        vr_sum = (CFG_W+1)'(i_state.vert_remainder) + (CFG_W+1)'(sh) - (CFG_W+1)'(th);
        if ((CNT_W+1)'(i_state.src_column) + (CNT_W+1)'(1) >= (CNT_W+1)'(sw)) begin
            if (row_active) begin
                o_state.vert_remainder = CFG_W'(vr_sum);
                o_state.dst_row        = i_state.dst_row + CNT_W'(1);
            end else if (i_state.vert_remainder >= th) begin
                o_state.vert_remainder = i_state.vert_remainder - th;
            end else begin
                o_state.vert_remainder = '0;
            end
            o_state.src_column      = '0;
            o_state.dst_column      = '0;
            o_state.sample_in_pixel = '0;
            o_state.horiz_remainder = '0;
            o_state.sum_first       = '0;
            o_state.sum_second      = '0;
            o_state.sum_third       = '0;
            if ((CNT_W+1)'(i_state.src_row) + (CNT_W+1)'(1) >= (CNT_W+1)'(sh)) begin
                o_state.src_row        = '0;
                o_state.dst_row        = '0;
                o_state.vert_remainder = '0;
            end else begin
                o_state.src_row = i_state.src_row + CNT_W'(1);
            end
        end else begin
            o_state.src_column = i_state.src_column + CNT_W'(1);
        end
    end

endmodule

// ===== rtl/image_row_subsample_downscaler_unit.sv =====
// Usage notes
// Streaming frame downscaler. Source pixels (three byte channels) enter in
// raster order on the input valid/ready channel, one transaction per pixel.
// Each output row takes one source row; each output pixel is the truncated
// mean of three row samples, with channels leaving in reversed order.
// Results leave on the output valid/ready channel with column, row and a
// frame_done flag on the last pixel of the frame. Source pixels that feed no
// output only advance the counters.
// Sizes are written on the configuration channel (index 0..3: source width,
// source height, target width, target height) while no pixel is in flight;
// it is always ready.
// A pixel accepted into the input register passes the combinational step; its
// result, if any, is loaded into the result register and shown on o_out_valid.
// The unit takes one pixel per cycle while the result register can take a value.
// When the receiver stalls with a result held, the step stops and the input
// register holds one more pixel; o_in_ready then drops until drained.
// Reset (i_rst_n low, synchronous) empties both registers, clears counters
// and remainders and restores the default sizes 640x480 to 64x64.
module image_row_subsample_downscaler_unit #(
    parameter int MAX_DIM = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  irsd_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output irsd_pkg::t_out_item           o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [irsd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [irsd_pkg::CFG_W-1:0]    i_cfg_data
);
    import irsd_pkg::*;

    t_cfg      r_cfg;
    t_state    r_state, n_state;
    t_in_item  r_in;
    logic      r_in_valid;
    t_out_item r_out, n_out;
    logic      r_out_valid;
    logic      step_emit;
    logic      advance;

    // Step advances when the input register holds a pixel and the result register can take a new value
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_width  <= RST_SOURCE_WIDTH;
            r_cfg.source_height <= RST_SOURCE_HEIGHT;
            r_cfg.target_width  <= RST_TARGET_WIDTH;
            r_cfg.target_height <= RST_TARGET_HEIGHT;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_SOURCE_WIDTH:  r_cfg.source_width  <= i_cfg_data;
                REG_SOURCE_HEIGHT: r_cfg.source_height <= i_cfg_data;
                REG_TARGET_WIDTH:  r_cfg.target_width  <= i_cfg_data;
                REG_TARGET_HEIGHT: r_cfg.target_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    irsd_step #(
        .MAX_DIM(MAX_DIM)
    ) u_step (
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .i_pixel (r_in),
        .o_state (n_state),
        .o_emit  (step_emit),
        .o_result(n_out)
    );

    // Step state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register: load on a produced result, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step_emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_emit) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.sample_in_pixel != SAMPLES_PER_PIXEL)
        else $error("sample counter reached a full pixel without emitting");

    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.sum_first <= SUM_W'(510)) && (r_state.sum_second <= SUM_W'(510)) &&
        (r_state.sum_third <= SUM_W'(510)))
        else $error("partial box sum exceeds two samples");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input stalled without a held result");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_in_valid))
        else $error("result appeared without a pixel in the step");
`endif

endmodule

// ===== bench/image_row_subsample_downscaler_unit_tb.sv =====
// Self-checking bench for image_row_subsample_downscaler_unit: raster pixel
// transactions in, downscaled pixel transactions out, each checked in order.
// Depends on irsd_pkg and the unit under test only.
`timescale 1ns / 100ps

module image_row_subsample_downscaler_unit_tb;
    import irsd_pkg::*;

    localparam int DIM_LIMIT     = 4096;
    localparam int RANDOM_PIXELS = 960;
    localparam int EDGE_PIXELS   = 120;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    localparam int LONG_HOLD     = 300;
    localparam int CYCLE_LIMIT   = 1500000;

    typedef enum logic [1:0] {
        FEED_PIXEL,
        FEED_REG_WRITE,
        FEED_FLUSH
    } t_feed_kind;

    typedef struct packed {
        t_feed_kind       kind;
        t_in_item         pixel;
        t_cfg_reg         index;
        logic [CFG_W-1:0] value;
        logic [15:0]      gap;
        logic             hold;
    } t_feed_entry;

    // Block ports
    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_in_valid   = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in_data    = '0;
    logic                 o_out_valid;
    logic                 i_out_ready  = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_valid  = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [CFG_W-1:0]     i_cfg_data   = '0;

    // Pending source transactions and expected downscaled pixels
    t_feed_entry feed_q[$];
    t_out_item   expected_q[$];
    int unsigned plan [4];

    // Downscaler copy: sizes and running state
    logic [CFG_W-1:0]  size_src_w = RST_SOURCE_WIDTH;
    logic [CFG_W-1:0]  size_src_h = RST_SOURCE_HEIGHT;
    logic [CFG_W-1:0]  size_dst_w = RST_TARGET_WIDTH;
    logic [CFG_W-1:0]  size_dst_h = RST_TARGET_HEIGHT;
    logic [CNT_W-1:0]  src_col    = '0;
    logic [CNT_W-1:0]  src_row    = '0;
    logic [CNT_W-1:0]  dst_col    = '0;
    logic [CNT_W-1:0]  dst_row    = '0;
    logic [SPL_W-1:0]  samples    = '0;
    logic [HREM_W-1:0] horiz_rem  = '0;
    logic [CFG_W-1:0]  vert_rem   = '0;
    logic [SUM_W-1:0]  acc_first  = '0;
    logic [SUM_W-1:0]  acc_second = '0;
    logic [SUM_W-1:0]  acc_third  = '0;

    // Handshake bookkeeping shared between the clocked processes
    bit          pixel_taken  = 1'b0;
    bit          reg_taken    = 1'b0;
    int unsigned quiet_cycles = 0;
    int unsigned gap_left     = 0;
    int unsigned hold_calls   = 0;
    int unsigned hold_seen    = 0;
    int unsigned stall_left   = 0;
    int unsigned steady_left  = 0;
    int unsigned cycle_count  = 0;
    int unsigned mismatches   = 0;

    image_row_subsample_downscaler_unit #(
        .MAX_DIM(DIM_LIMIT)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    function automatic int unsigned clamp_size(input int unsigned v);
        if (v < 1) return 1;
        if (v > DIM_LIMIT) return DIM_LIMIT;
        return v;
    endfunction

    // Advance the downscaler by one source pixel; return 1 when it completes an output pixel
    function automatic bit downscale_pixel(input t_in_item px, output t_out_item res);
        int unsigned sw;
        int unsigned sh;
        int unsigned tw;
        int unsigned th;
        int unsigned span;
        bit          row_on;
        bit          made;
        made = 1'b0;
        res  = '0;
        sw = clamp_size(size_src_w);
        sh = clamp_size(size_src_h);
        tw = clamp_size(size_dst_w);
        th = clamp_size(size_dst_h);
        if (tw > sw) tw = sw;
        if (th > sh) th = sh;
        span   = 3 * tw;
        row_on = (dst_row < th) && (vert_rem < th);

        // take up to three samples of this pixel while the row still wants them
        if (row_on) begin
            for (int k = 0; k < SAMPLES_PER_PIXEL && dst_col < tw && horiz_rem < span; k++) begin
                acc_first  += px.chan_first;
                acc_second += px.chan_second;
                acc_third  += px.chan_third;
                samples++;
                horiz_rem += sw;
                if (samples >= SAMPLES_PER_PIXEL) begin
                    res.avg_of_third  = CHAN_W'(acc_third / 3);
                    res.avg_of_second = CHAN_W'(acc_second / 3);
                    res.avg_of_first  = CHAN_W'(acc_first / 3);
                    res.out_column    = dst_col[IDX_W-1:0];
                    res.out_row       = dst_row[IDX_W-1:0];
                    res.frame_done    = (dst_col + 1 == tw) && (dst_row + 1 == th);
                    made       = 1'b1;
                    dst_col++;
                    samples    = '0;
                    acc_first  = '0;
                    acc_second = '0;
                    acc_third  = '0;
                end
            end
            if (horiz_rem >= span) horiz_rem -= span;
            else horiz_rem = '0;
        end

        // advance the raster position, wrap rows and frames
        if (src_col + 1 >= sw) begin
            if (row_on) begin
                vert_rem = vert_rem + sh - th;
                dst_row++;
            end else if (vert_rem >= th) begin
                vert_rem -= th;
            end else begin
                vert_rem = '0;
            end
            src_col    = '0;
            dst_col    = '0;
            samples    = '0;
            horiz_rem  = '0;
            acc_first  = '0;
            acc_second = '0;
            acc_third  = '0;
            if (src_row + 1 >= sh) begin
                src_row  = '0;
                dst_row  = '0;
                vert_rem = '0;
            end else begin
                src_row++;
            end
        end else begin
            src_col++;
        end
        return made;
    endfunction

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 9);
        return $urandom_range(15, 40);
    endfunction

    // Mostly small sizes, now and then the out-of-range and largest codes
    function automatic int unsigned pick_size(input int unsigned hi);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 4) return 0;
        if (r < 7) return (1 << CFG_W) - 1;
        if (r < 9) return DIM_LIMIT;
        return $urandom_range(1, hi);
    endfunction

    function automatic t_in_item any_pixel();
        t_in_item px;
        px.chan_first  = CHAN_W'($urandom);
        px.chan_second = CHAN_W'($urandom);
        px.chan_third  = CHAN_W'($urandom);
        return px;
    endfunction

    task automatic push_pixel(input t_in_item px, input int unsigned gap, input bit hold);
        t_feed_entry e;
        e       = '0;
        e.kind  = FEED_PIXEL;
        e.pixel = px;
        e.gap   = 16'(gap);
        e.hold  = hold;
        feed_q.push_back(e);
    endtask

    task automatic push_write(input t_cfg_reg index, input int unsigned value);
        t_feed_entry e;
        e       = '0;
        e.kind  = FEED_REG_WRITE;
        e.index = index;
        e.value = CFG_W'(value);
        feed_q.push_back(e);
        plan[int'(index)] = value;
    endtask

    task automatic push_flush();
        t_feed_entry e;
        e      = '0;
        e.kind = FEED_FLUSH;
        feed_q.push_back(e);
    endtask

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[image_row_subsample_downscaler_unit] ERROR");
            $finish;
        end
    end

    // Sample the three channels at the rising edge: predict, check, note quiet time
    always @(posedge i_clk) begin
        t_out_item fresh;
        t_out_item want;
        pixel_taken = 1'b0;
        reg_taken   = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                reg_taken = 1'b1;
                case (t_cfg_reg'(i_cfg_index))
                    REG_SOURCE_WIDTH:  size_src_w = i_cfg_data;
                    REG_SOURCE_HEIGHT: size_src_h = i_cfg_data;
                    REG_TARGET_WIDTH:  size_dst_w = i_cfg_data;
                    REG_TARGET_HEIGHT: size_dst_h = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                pixel_taken = 1'b1;
                if (downscale_pixel(i_in_data, fresh)) expected_q.push_back(fresh);
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: output transaction with nothing pending: col %0d row %0d",
                             $time, o_out_data.out_column, o_out_data.out_row);
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("avg_of_third", want.avg_of_third, o_out_data.avg_of_third);
                    check_field("avg_of_second", want.avg_of_second, o_out_data.avg_of_second);
                    check_field("avg_of_first", want.avg_of_first, o_out_data.avg_of_first);
                    check_field("out_column", want.out_column, o_out_data.out_column);
                    check_field("out_row", want.out_row, o_out_data.out_row);
                    check_field("frame_done", want.frame_done, o_out_data.frame_done);
                end
            end
            if (pixel_taken || expected_q.size() != 0) quiet_cycles = 0;
            else if (quiet_cycles < SETTLE_CYCLES) quiet_cycles++;
        end
    end

    // Drive pixel and register transactions from the feed queue at the falling edge
    always @(negedge i_clk) begin
        t_feed_entry      head;
        logic             in_v;
        logic             cfg_v;
        t_in_item         in_d;
        logic [CFG_IDX_W-1:0] cfg_i;
        logic [CFG_W-1:0] cfg_d;
        in_v  = i_in_valid;
        cfg_v = i_cfg_valid;
        in_d  = i_in_data;
        cfg_i = i_cfg_index;
        cfg_d = i_cfg_data;

        // drop what the last edge accepted
        if (in_v && pixel_taken) in_v = 1'b0;
        if (cfg_v && reg_taken) cfg_v = 1'b0;

        if (i_rst_n && !in_v && !cfg_v) begin
            if (gap_left != 0) begin
                gap_left--;
            end else if (feed_q.size() != 0) begin
                head = feed_q[0];
                case (head.kind)
                    FEED_PIXEL: begin
                        void'(feed_q.pop_front());
                        in_v     = 1'b1;
                        in_d     = head.pixel;
                        gap_left = head.gap;
                        if (head.hold) hold_calls <= hold_calls + 1;
                    end
                    // write sizes only once the block has gone quiet
                    FEED_REG_WRITE: begin
                        if (expected_q.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
                            void'(feed_q.pop_front());
                            cfg_v = 1'b1;
                            cfg_i = head.index;
                            cfg_d = head.value;
                        end
                    end
                    FEED_FLUSH: begin
                        if (expected_q.size() == 0) void'(feed_q.pop_front());
                    end
                    default: void'(feed_q.pop_front());
                endcase
            end
        end

        i_in_valid  <= in_v;
        i_in_data   <= in_d;
        i_cfg_valid <= cfg_v;
        i_cfg_index <= cfg_i;
        i_cfg_data  <= cfg_d;
    end

    // Output side: random stalls, steady stretches, and a long hold-off on request
    always @(negedge i_clk) begin
        int unsigned r;
        if (hold_seen != hold_calls) begin
            hold_seen  = hold_calls;
            stall_left = LONG_HOLD;
        end
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (steady_left != 0) begin
            steady_left--;
            i_out_ready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                steady_left = $urandom_range(20, 120);
                i_out_ready <= 1'b1;
            end else if (r < 60) begin
                i_out_ready <= 1'b1;
            end else if (r < 95) begin
                stall_left = $urandom_range(0, 2);
                i_out_ready <= 1'b0;
            end else begin
                stall_left = $urandom_range(8, 30);
                i_out_ready <= 1'b0;
            end
        end
    end

    // Build the stimulus, run reset, wait for the block to drain
    initial begin
        t_in_item    px;
        int unsigned eff_sw;
        int unsigned eff_sh;
        int unsigned hi;
        int unsigned frame_px;
        int unsigned n_px;
        int unsigned flush_at;
        int unsigned random_px;
        bit          burst;

        plan[int'(REG_SOURCE_WIDTH)]  = RST_SOURCE_WIDTH;
        plan[int'(REG_SOURCE_HEIGHT)] = RST_SOURCE_HEIGHT;
        plan[int'(REG_TARGET_WIDTH)]  = RST_TARGET_WIDTH;
        plan[int'(REG_TARGET_HEIGHT)] = RST_TARGET_HEIGHT;

        // reset sizes, channel extremes
        for (int i = 0; i < 8; i++) begin
            case (i % 3)
                0:       px = {8'hFF, 8'hFF, 8'hFF};
                1:       px = {8'h00, 8'h00, 8'h00};
                default: px = {8'hFF, 8'h00, 8'h80};
            endcase
            push_pixel(px, pick_gap(), 1'b0);
        end

        // zero sizes count as one: every pixel is a whole frame
        push_write(REG_SOURCE_WIDTH, 0);
        push_write(REG_SOURCE_HEIGHT, 0);
        push_write(REG_TARGET_WIDTH, 0);
        push_write(REG_TARGET_HEIGHT, 0);
        push_pixel({8'hFF, 8'hFF, 8'hFF}, 0, 1'b0);
        push_pixel({8'h00, 8'h00, 8'h00}, 0, 1'b0);
        push_pixel({8'hFF, 8'h00, 8'hFF}, 1, 1'b0);

        // targets above the source are cut back, no upscaling; run into the next frame
        push_write(REG_SOURCE_WIDTH, 3);
        push_write(REG_SOURCE_HEIGHT, 2);
        push_write(REG_TARGET_WIDTH, (1 << CFG_W) - 1);
        push_write(REG_TARGET_HEIGHT, 9);
        for (int i = 0; i < 7; i++) push_pixel(any_pixel(), pick_gap(), 1'b0);

        // skipped rows and pixels, a pause for all results, then sizes change mid frame
        push_write(REG_SOURCE_WIDTH, 5);
        push_write(REG_SOURCE_HEIGHT, 3);
        push_write(REG_TARGET_WIDTH, 2);
        push_write(REG_TARGET_HEIGHT, 2);
        for (int i = 0; i < 7; i++) push_pixel(any_pixel(), pick_gap(), 1'b0);
        push_flush();
        push_pixel(any_pixel(), 0, 1'b0);
        push_pixel(any_pixel(), 0, 1'b0);
        push_write(REG_SOURCE_WIDTH, 3);
        push_write(REG_TARGET_WIDTH, 3);
        for (int i = 0; i < 5; i++) push_pixel(any_pixel(), pick_gap(), 1'b0);

        // widest row, back to back, with a long output hold-off partway through
        push_write(REG_SOURCE_WIDTH, (1 << CFG_W) - 1);
        push_write(REG_SOURCE_HEIGHT, 1);
        push_write(REG_TARGET_WIDTH, DIM_LIMIT);
        push_write(REG_TARGET_HEIGHT, 1);
        for (int i = 0; i < EDGE_PIXELS; i++) push_pixel(any_pixel(), 0, i == 30);

        // tallest column
        push_write(REG_SOURCE_WIDTH, 1);
        push_write(REG_SOURCE_HEIGHT, DIM_LIMIT);
        push_write(REG_TARGET_WIDTH, 1);
        push_write(REG_TARGET_HEIGHT, (1 << CFG_W) - 1);
        for (int i = 0; i < EDGE_PIXELS; i++)
            push_pixel(any_pixel(), (i < 80) ? 0 : pick_gap(), i == 60);

        // random sizes: mostly whole frames, sometimes a partial frame left behind
        random_px = 0;
        while (random_px < RANDOM_PIXELS) begin
            if ($urandom_range(0, 9) < 7) push_write(REG_SOURCE_WIDTH, pick_size(24));
            if ($urandom_range(0, 9) < 7) push_write(REG_SOURCE_HEIGHT, pick_size(10));
            eff_sw = clamp_size(plan[int'(REG_SOURCE_WIDTH)]);
            eff_sh = clamp_size(plan[int'(REG_SOURCE_HEIGHT)]);
            if ($urandom_range(0, 9) < 7) begin
                hi = (eff_sw + 2 > 30) ? 30 : eff_sw + 2;
                push_write(REG_TARGET_WIDTH, pick_size(hi));
            end
            if ($urandom_range(0, 9) < 7) begin
                hi = (eff_sh + 2 > 30) ? 30 : eff_sh + 2;
                push_write(REG_TARGET_HEIGHT, pick_size(hi));
            end
            frame_px = eff_sw * eff_sh;
            if (frame_px > 240) begin
                n_px = $urandom_range(10, 120);
            end else begin
                n_px = frame_px * $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0) n_px += $urandom_range(0, frame_px - 1);
            end
            burst    = ($urandom_range(0, 3) == 0);
            flush_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n_px - 1) : n_px;
            for (int i = 0; i < n_px; i++) begin
                if (i == flush_at) push_flush();
                push_pixel(any_pixel(), burst ? 0 : pick_gap(), 1'b0);
            end
            random_px += n_px;
        end

        // hold reset low, then release it on a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (feed_q.size() != 0 || i_in_valid || i_cfg_valid || expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("[image_row_subsample_downscaler_unit] OK");
        end else begin
            $display("[image_row_subsample_downscaler_unit] ERROR");
        end
        $finish;
    end

endmodule
